>>> rtl/vnem_pkg.sv
// ============================================================================
// vnem_pkg
// Shared types, constants and helpers for the negate / edge / motion pipeline
// ============================================================================
`default_nettype none

package vnem_pkg;

    // channel and field widths
    localparam int PIX_W      = 8;
    localparam int NUM_CH     = 3;
    localparam int SIZE_W     = 11;
    localparam int COUNT_W    = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // register reset values
    localparam logic [SIZE_W-1:0]  RST_WIDTH      = SIZE_W'(640);
    localparam logic [SIZE_W-1:0]  RST_HEIGHT     = SIZE_W'(480);
    localparam logic [PIX_W-1:0]   RST_PIX_THR    = PIX_W'(64);
    localparam logic [COUNT_W-1:0] RST_CHANGE_THR = COUNT_W'(10);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEGATE     = 3'd0,
        CFG_EDGE       = 3'd1,
        CFG_MOTION     = 3'd2,
        CFG_WIDTH      = 3'd3,
        CFG_HEIGHT     = 3'd4,
        CFG_PIX_THR    = 3'd5,
        CFG_CHANGE_THR = 3'd6
    } t_cfg_idx;

    // one pixel, channel 0 (red) in the low byte
    typedef logic [NUM_CH-1:0][PIX_W-1:0] t_rgb;

    // what the lanes found for the motion sample of one pixel
    typedef struct packed {
        logic             hit;     // one byte of this pixel is sampled
        logic             offset;  // sampled byte is not the first channel
        logic [PIX_W-1:0] data;    // processed value of the sampled byte
    } t_sample;

    // effective frame size: zero acts as one, clamp to the maximum
    function automatic int eff_size(input logic [SIZE_W-1:0] v, input int maxv);
        int r;
        if (v == '0) begin
            r = 1;
        end else if (int'(v) > maxv) begin
            r = maxv;
        end else begin
            r = int'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/vnem_ram.sv
// ============================================================================
// vnem_ram
// Generic single write port RAM with one registered read port
// ============================================================================
`default_nettype none

module vnem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/vnem_lane.sv
// ============================================================================
// vnem_lane
// One channel lane: negation, neighbour difference edge step, sample phase
// ============================================================================
`default_nettype none

module vnem_lane
    import vnem_pkg::*;
#(
    parameter int LANE      = 0,
    parameter int BYTE_STEP = 13,
    localparam int BP_W     = $clog2(BYTE_STEP)
) (
    input  wire logic [PIX_W-1:0] i_value,
    input  wire logic [PIX_W-1:0] i_prev,
    input  wire logic             i_negate,
    input  wire logic             i_edge_active,
    input  wire logic [BP_W-1:0]  i_phase,
    output logic      [PIX_W-1:0] o_neg,
    output logic      [PIX_W-1:0] o_res,
    output logic                  o_hit
);

    logic [PIX_W-1:0] diff;
    int               pos;

    // optional inversion
    assign o_neg = i_negate ? ~i_value : i_value;

    // absolute difference to the previous pixel, times four, wrapped
    always_comb begin
        diff = (o_neg > i_prev) ? (o_neg - i_prev) : (i_prev - o_neg);
        o_res = i_edge_active ? {diff[PIX_W-3:0], 2'b00} : o_neg;
    end

    // byte of this lane falls on a multiple of the byte step
    always_comb begin
        pos   = int'(i_phase) + LANE;
        o_hit = (pos == 0) || (pos == BYTE_STEP);
    end

endmodule

`default_nettype wire

>>> rtl/vnem_merge.sv
// ============================================================================
// vnem_merge
// Merges the lane results into the single motion sample of a pixel
// ============================================================================
`default_nettype none

module vnem_merge
    import vnem_pkg::*;
(
    input  wire logic              i_sample_en,
    input  wire t_rgb              i_res,
    input  wire logic [NUM_CH-1:0] i_hit,
    output t_sample                o_sample
);

    // at most one lane hits, since the byte step spans all three channels
    always_comb begin
        o_sample.hit    = 1'b0;
        o_sample.offset = 1'b0;
        o_sample.data   = i_res[0];
        if (i_sample_en) begin
            if (i_hit[0]) begin
                o_sample.hit  = 1'b1;
                o_sample.data = i_res[0];
            end else if (i_hit[1]) begin
                o_sample.hit    = 1'b1;
                o_sample.offset = 1'b1;
                o_sample.data   = i_res[1];
            end else if (i_hit[2]) begin
                o_sample.hit    = 1'b1;
                o_sample.offset = 1'b1;
                o_sample.data   = i_res[2];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/video_negate_edge_motion.sv
// ============================================================================
// video_negate_edge_motion
// RGB pixel pipeline with negation, edge step and sampled motion detection
// ============================================================================
// Takes one pixel per clock in raster order while neither a held output nor
// a clearing pass stalls it. A pixel passes a compare stage and then an
// output register, from which its result is offered. Input ready follows
// output ready through both stages: with the output ready a pixel is taken
// on every clock, and a result held on the output stalls the input once the
// compare stage is full too. Three channel lanes negate and edge-filter the
// pixel; a merge stage picks the one byte per pixel that the motion sampler
// may hit, reads its value of the previous frame from the store RAM and
// counts changes. After reset, and after any write that changes the
// effective frame size, the store is zeroed by a clearing pass of one entry
// per cycle over all ceil(MAX_HEIGHT/ROW_STEP) * ceil(3*MAX_WIDTH/BYTE_STEP)
// entries (81054 with the defaults), a rate set by the single write port of
// the store; no pixel is accepted during that pass, configuration writes are.
`default_nettype none

module video_negate_edge_motion
    import vnem_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int ROW_STEP   = 3,
    parameter int BYTE_STEP  = 13
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration writes
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // pixel input
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [23:0]           s_axis_tdata,  // red_in, green_in, blue_in
    // pixel output
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [47:0]                m_axis_tdata,  // red_out, green_out, blue_out,
                                                      // changed_count, zero pad
    output logic                       m_axis_tlast,  // frame_end
    output logic                       m_axis_tuser   // refresh
);

    localparam int STORE_ROWS = (MAX_HEIGHT + ROW_STEP - 1) / ROW_STEP;
    localparam int STORE_COLS = (3 * MAX_WIDTH + BYTE_STEP - 1) / BYTE_STEP;
    localparam int STORE_SIZE = STORE_ROWS * STORE_COLS;
    localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WE_W       = $clog2(MAX_WIDTH + 1);
    localparam int HE_W       = $clog2(MAX_HEIGHT + 1);
    localparam int RP_W       = (ROW_STEP > 1) ? $clog2(ROW_STEP) : 1;
    localparam int BP_W       = $clog2(BYTE_STEP);
    localparam int Q_W        = $clog2(STORE_COLS + 1);
    localparam int PAD_W      = 48 - NUM_CH * PIX_W - COUNT_W;

    // configuration registers
    logic                r_negate_en, r_edge_en, r_motion_en;
    logic [SIZE_W-1:0]   r_frame_width, r_frame_height;
    logic [PIX_W-1:0]    r_pix_thr;
    logic [COUNT_W-1:0]  r_change_thr;

    // position and frame state
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic [RP_W-1:0]     r_row_phase;
    logic [ADDR_W-1:0]   r_row_base;
    logic [BP_W-1:0]     r_byte_phase;
    logic [Q_W-1:0]      r_col_quot;
    t_rgb                r_prev;
    logic [COUNT_W-1:0]  r_count;

    // clearing pass
    logic                r_clear_busy;
    logic [ADDR_W-1:0]   r_clear_addr;

    // compare stage
    logic                r_b_valid;
    t_rgb                r_b_res;
    logic                r_b_hit;
    logic [ADDR_W-1:0]   r_b_addr;
    logic [PIX_W-1:0]    r_b_byte;
    logic                r_b_last;
    logic                r_b_fwd;
    logic [PIX_W-1:0]    r_b_fwd_data;

    // output register
    logic                r_o_valid;
    t_rgb                r_o_res;
    logic [COUNT_W-1:0]  r_o_count;
    logic                r_o_last;
    logic                r_o_refresh;

    logic [WE_W-1:0]     w_eff;
    logic [HE_W-1:0]     h_eff;
    logic                size_change;
    logic                accept, b_adv;
    logic                last_col, last_row;
    t_rgb                pix_in, lane_neg, lane_res;
    logic [NUM_CH-1:0]   lane_hit;
    logic                edge_active, sample_en;
    t_sample             sample;
    logic [ADDR_W-1:0]   a_addr;
    logic [BP_W+1:0]     phase_sum;
    logic [PIX_W-1:0]    store_rdata, stored, cmp_diff;
    logic                changed;
    logic [COUNT_W-1:0]  n_count;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [PIX_W-1:0]    ram_wdata;

    // effective frame size and size change detection on a write
    always_comb begin
        w_eff       = WE_W'(eff_size(r_frame_width, MAX_WIDTH));
        h_eff       = HE_W'(eff_size(r_frame_height, MAX_HEIGHT));
        size_change = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  size_change = eff_size(i_cfg_data[SIZE_W-1:0], MAX_WIDTH)
                                          != int'(w_eff);
                CFG_HEIGHT: size_change = eff_size(i_cfg_data[SIZE_W-1:0], MAX_HEIGHT)
                                          != int'(h_eff);
                default:    size_change = 1'b0;
            endcase
        end
    end

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_negate_en    <= 1'b0;
            r_edge_en      <= 1'b0;
            r_motion_en    <= 1'b0;
            r_frame_width  <= RST_WIDTH;
            r_frame_height <= RST_HEIGHT;
            r_pix_thr      <= RST_PIX_THR;
            r_change_thr   <= RST_CHANGE_THR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NEGATE:     r_negate_en    <= i_cfg_data[0];
                CFG_EDGE:       r_edge_en      <= i_cfg_data[0];
                CFG_MOTION:     r_motion_en    <= i_cfg_data[0];
                CFG_WIDTH:      r_frame_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_HEIGHT:     r_frame_height <= i_cfg_data[SIZE_W-1:0];
                CFG_PIX_THR:    r_pix_thr      <= i_cfg_data[PIX_W-1:0];
                CFG_CHANGE_THR: r_change_thr   <= i_cfg_data[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // handshakes
    assign b_adv         = r_b_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_clear_busy && (!r_b_valid || b_adv);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign pix_in      = s_axis_tdata;
    assign edge_active = r_edge_en && (r_col != '0);
    assign sample_en   = r_motion_en && (r_row_phase == '0);
    assign last_col    = (int'(r_col) + 1) >= int'(w_eff);
    assign last_row    = (int'(r_row) + 1) >= int'(h_eff);

    // channel lanes
    for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
        vnem_lane #(
            .LANE      (c),
            .BYTE_STEP (BYTE_STEP)
        ) u_lane (
            .i_value       (pix_in[c]),
            .i_prev        (r_prev[c]),
            .i_negate      (r_negate_en),
            .i_edge_active (edge_active),
            .i_phase       (r_byte_phase),
            .o_neg         (lane_neg[c]),
            .o_res         (lane_res[c]),
            .o_hit         (lane_hit[c])
        );
    end

    // merge of the lane sample hits
    vnem_merge u_merge (
        .i_sample_en (sample_en),
        .i_res       (lane_res),
        .i_hit       (lane_hit),
        .o_sample    (sample)
    );

    // store address of the sampled byte
    assign a_addr    = r_row_base + ADDR_W'(r_col_quot) + ADDR_W'(sample.offset);
    assign phase_sum = (BP_W+2)'(r_byte_phase) + (BP_W+2)'(3);

    // raster position, sample phases and previous pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || size_change) begin
            r_col        <= '0;
            r_row        <= '0;
            r_row_phase  <= '0;
            r_row_base   <= '0;
            r_byte_phase <= '0;
            r_col_quot   <= '0;
            r_prev       <= '0;
        end else if (accept) begin
            r_prev <= lane_neg;
            if (last_col) begin
                r_col        <= '0;
                r_byte_phase <= '0;
                r_col_quot   <= '0;
                if (last_row) begin
                    r_row       <= '0;
                    r_row_phase <= '0;
                    r_row_base  <= '0;
                end else begin
                    r_row <= r_row + ROW_W'(1);
                    if (int'(r_row_phase) == ROW_STEP - 1) begin
                        r_row_phase <= '0;
                        r_row_base  <= r_row_base + ADDR_W'(STORE_COLS);
                    end else begin
                        r_row_phase <= r_row_phase + RP_W'(1);
                    end
                end
            end else begin
                r_col <= r_col + COL_W'(1);
                if (int'(phase_sum) >= BYTE_STEP) begin
                    r_byte_phase <= BP_W'(int'(phase_sum) - BYTE_STEP);
                    r_col_quot   <= r_col_quot + Q_W'(1);
                end else begin
                    r_byte_phase <= BP_W'(phase_sum);
                end
            end
        end
    end

    // clearing pass over the store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || size_change) begin
            r_clear_busy <= 1'b1;
            r_clear_addr <= '0;
        end else if (r_clear_busy) begin
            if (int'(r_clear_addr) == STORE_SIZE - 1) begin
                r_clear_busy <= 1'b0;
            end
            r_clear_addr <= r_clear_addr + ADDR_W'(1);
        end
    end

    // compare stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (accept) begin
            r_b_valid <= 1'b1;
        end else if (b_adv) begin
            r_b_valid <= 1'b0;
        end
    end

    // compare stage payload, forward a same-address write of this edge
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_res      <= lane_res;
            r_b_hit      <= sample.hit;
            r_b_addr     <= a_addr;
            r_b_byte     <= sample.data;
            r_b_last     <= last_col && last_row;
            r_b_fwd      <= b_adv && r_b_hit && (r_b_addr == a_addr);
            r_b_fwd_data <= r_b_byte;
        end
    end

    // previous frame store
    always_comb begin
        if (r_clear_busy) begin
            ram_we    = 1'b1;
            ram_waddr = r_clear_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = b_adv && r_b_hit;
            ram_waddr = r_b_addr;
            ram_wdata = r_b_byte;
        end
    end

    vnem_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_SIZE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (a_addr),
        .o_rdata (store_rdata)
    );

    // change test and saturating count
    always_comb begin
        stored   = r_b_fwd ? r_b_fwd_data : store_rdata;
        cmp_diff = (r_b_byte > stored) ? (r_b_byte - stored) : (stored - r_b_byte);
        changed  = r_b_hit && (cmp_diff > r_pix_thr);
        n_count  = (changed && (r_count != COUNT_MAX)) ? r_count + COUNT_W'(1) : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || size_change) begin
            r_count <= '0;
        end else if (b_adv) begin
            r_count <= r_b_last ? '0 : n_count;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (b_adv) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_o_res     <= r_b_res;
            r_o_count   <= n_count;
            r_o_last    <= r_b_last;
            r_o_refresh <= r_b_last && !(r_motion_en && (n_count < r_change_thr));
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_o_count, r_o_res};
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tuser  = r_o_refresh;

    // no pixel enters while the store is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clear_busy |-> !s_axis_tready)
        else $error("pixel accepted during store clearing");

    // the clearing pass never competes with a sample write
    a_clear_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clear_busy |-> !(b_adv && r_b_hit))
        else $error("sample write during store clearing");

    // refresh is only raised on the last pixel of a frame
    a_refresh_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("refresh outside frame end");

    // a forwarded byte comes from a write at the edge that loaded the stage
    a_fwd_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && b_adv && r_b_hit && (r_b_addr == a_addr)) |=> r_b_fwd)
        else $error("store forwarding missed");

endmodule

`default_nettype wire

>>> bench/tb_video_negate_edge_motion.sv
// ============================================================================
// tb_video_negate_edge_motion
// Self-checking bench for the negate / edge / motion pixel pipeline
// ============================================================================
// Streams RGB pixels into the block under random valid and ready gaps and
// predicts every output transaction from a frame tracker that keeps its own
// copy of the registers, the column and row position, the previous pixel
// and the sampled store of the previous frame. Each output is checked field
// by field against the oldest prediction. Frame sizes go from a single pixel
// wide up to the maximum, and the thresholds and enables are changed between
// runs while the pipeline is empty.

// limits of the block as built
localparam int MAX_W      = 1024;
localparam int MAX_H      = 1024;
localparam int ROW_STEP   = 3;
localparam int BYTE_STEP  = 13;
localparam int STORE_ROWS = (MAX_H + ROW_STEP - 1) / ROW_STEP;
localparam int STORE_COLS = (3 * MAX_W + BYTE_STEP - 1) / BYTE_STEP;
localparam int STORE_SIZE = STORE_ROWS * STORE_COLS;

// register index that the block does not decode
localparam logic [vnem_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

// one output transaction as it should appear
typedef struct packed {
    logic [vnem_pkg::COUNT_W-1:0] count;
    logic                         refresh;
    logic                         frame_end;
    vnem_pkg::t_rgb               pix;
} t_pixel_result;

// tracks frame position and sampled history, queues the outputs to come
class motion_frame_tracker;
    bit                            negate_on;
    bit                            edge_on;
    bit                            motion_on;
    logic [vnem_pkg::SIZE_W-1:0]   width_reg;
    logic [vnem_pkg::SIZE_W-1:0]   height_reg;
    logic [vnem_pkg::PIX_W-1:0]    pixel_thr;
    logic [vnem_pkg::COUNT_W-1:0]  change_thr;

    logic [7:0]                    frame_store [STORE_SIZE];
    vnem_pkg::t_rgb                last_pixel;
    int                            col;
    int                            row;
    int                            phase;
    logic [vnem_pkg::COUNT_W-1:0]  change_count;

    t_pixel_result                 awaited_pixels [$];
    int                            mismatch_total;
    int                            out_index;

    function new();
        negate_on      = 1'b0;
        edge_on        = 1'b0;
        motion_on      = 1'b0;
        width_reg      = vnem_pkg::RST_WIDTH;
        height_reg     = vnem_pkg::RST_HEIGHT;
        pixel_thr      = vnem_pkg::RST_PIX_THR;
        change_thr     = vnem_pkg::RST_CHANGE_THR;
        mismatch_total = 0;
        out_index      = 0;
        restart();
    endfunction

    function int clamp_dim(logic [vnem_pkg::SIZE_W-1:0] v, int top);
        if (v == '0) return 1;
        if (int'(v) > top) return top;
        return int'(v);
    endfunction

    function int abs_diff(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // new frame from scratch: history, position and count all cleared
    function void restart();
        foreach (frame_store[i]) frame_store[i] = '0;
        last_pixel   = '0;
        col          = 0;
        row          = 0;
        phase        = 0;
        change_count = '0;
    endfunction

    function void write_reg(logic [vnem_pkg::CFG_IDX_W-1:0] idx,
                            logic [vnem_pkg::CFG_DATA_W-1:0] data);
        int old_w;
        int old_h;
        old_w = clamp_dim(width_reg, MAX_W);
        old_h = clamp_dim(height_reg, MAX_H);
        case (idx)
            vnem_pkg::CFG_NEGATE:     negate_on  = data[0];
            vnem_pkg::CFG_EDGE:       edge_on    = data[0];
            vnem_pkg::CFG_MOTION:     motion_on  = data[0];
            vnem_pkg::CFG_WIDTH:      width_reg  = data[vnem_pkg::SIZE_W-1:0];
            vnem_pkg::CFG_HEIGHT:     height_reg = data[vnem_pkg::SIZE_W-1:0];
            vnem_pkg::CFG_PIX_THR:    pixel_thr  = data[vnem_pkg::PIX_W-1:0];
            vnem_pkg::CFG_CHANGE_THR: change_thr = data[vnem_pkg::COUNT_W-1:0];
            default: return;
        endcase
        // only a change of the effective size starts over
        if (clamp_dim(width_reg, MAX_W) != old_w || clamp_dim(height_reg, MAX_H) != old_h)
            restart();
    endfunction

    // one accepted pixel: work out its output and advance the position
    function void take_pixel(vnem_pkg::t_rgb px);
        vnem_pkg::t_rgb neg;
        vnem_pkg::t_rgb res;
        t_pixel_result  r;
        int             w;
        int             h;
        int             d;
        int             byte_pos;
        int             slot;
        logic           last;
        w = clamp_dim(width_reg, MAX_W);
        h = clamp_dim(height_reg, MAX_H);

        for (int c = 0; c < 3; c++)
            neg[c] = negate_on ? 8'hFF - px[c] : px[c];

        // edge step against the previous pixel, never on column 0
        for (int c = 0; c < 3; c++) begin
            if (edge_on && col != 0) begin
                d      = abs_diff(int'(neg[c]), int'(last_pixel[c]));
                res[c] = 8'(d * 4);
            end else begin
                res[c] = neg[c];
            end
        end
        last_pixel = neg;

        // sampled comparison with the previous frame
        if (motion_on && (row % ROW_STEP) == 0) begin
            for (int c = 0; c < 3; c++) begin
                if (((phase + c) % BYTE_STEP) == 0) begin
                    byte_pos = col * 3 + c;
                    slot     = (row / ROW_STEP) * STORE_COLS + byte_pos / BYTE_STEP;
                    if (slot < STORE_SIZE) begin
                        d = abs_diff(int'(res[c]), int'(frame_store[slot]));
                        if (d > pixel_thr && change_count != vnem_pkg::COUNT_MAX)
                            change_count++;
                        frame_store[slot] = res[c];
                    end
                end
            end
        end

        last        = (col + 1 >= w) && (row + 1 >= h);
        r.pix       = res;
        r.frame_end = last;
        r.refresh   = last && !(motion_on && change_count < change_thr);
        r.count     = change_count;
        awaited_pixels.push_back(r);

        // raster position
        if (col + 1 >= w) begin
            col   = 0;
            phase = 0;
            if (row + 1 >= h) begin
                row          = 0;
                change_count = '0;
            end else begin
                row++;
            end
        end else begin
            col++;
            phase = (phase + 3) % BYTE_STEP;
        end
    endfunction

    task flag_mismatch(string what);
        $display("output %0d: %s", out_index, what);
        mismatch_total++;
    endtask

    task match_output(vnem_pkg::t_rgb pix, logic fend, logic refr,
                      logic [vnem_pkg::COUNT_W-1:0] cnt);
        t_pixel_result exp_r;
        string         ch_name [3];
        ch_name = '{"red", "green", "blue"};
        if (awaited_pixels.size() == 0) begin
            flag_mismatch("output transaction with no pixel awaited");
        end else begin
            exp_r = awaited_pixels.pop_front();
            for (int c = 0; c < 3; c++)
                if (pix[c] !== exp_r.pix[c])
                    flag_mismatch($sformatf("%s got %0d, expected %0d",
                                            ch_name[c], pix[c], exp_r.pix[c]));
            if (fend !== exp_r.frame_end)
                flag_mismatch($sformatf("frame end got %b, expected %b",
                                        fend, exp_r.frame_end));
            if (refr !== exp_r.refresh)
                flag_mismatch($sformatf("refresh got %b, expected %b",
                                        refr, exp_r.refresh));
            if (cnt !== exp_r.count)
                flag_mismatch($sformatf("changed count got %0d, expected %0d",
                                        cnt, exp_r.count));
        end
        out_index++;
    endtask
endclass

module tb_video_negate_edge_motion;
    import vnem_pkg::*;

    localparam int P1_W    = 7;
    localparam int P1_H    = 7;
    localparam int P1_AREA = P1_W * P1_H;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata  = '0;   // red_in, green_in, blue_in
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [47:0]           m_axis_tdata;         // red_out, green_out, blue_out,
                                                 // changed_count, zero pad
    logic                  m_axis_tlast;         // frame_end
    logic                  m_axis_tuser;         // refresh

    motion_frame_tracker   tracker;
    int                    total_sent = 0;
    int                    stream_pos = 0;
    t_rgb                  frame_base [P1_AREA];
    bit                    hold_req   = 1'b0;
    bit                    hold_seen  = 1'b0;
    int                    hold_left  = 0;

    video_negate_edge_motion dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // idle share in percent: sender light first, then receiver light, then none
    function automatic int idle_pct(bit sender);
        if (total_sent < 450) return sender ? 20 : 59;
        if (total_sent < 900) return sender ? 59 : 20;
        return 0;
    endfunction

    // output side: check each transaction, random ready, long hold on request
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.match_output(m_axis_tdata[23:0], m_axis_tlast, m_axis_tuser,
                                 m_axis_tdata[44:24]);
        if (hold_req != hold_seen) begin
            hold_seen     <= hold_req;
            hold_left     <= 300;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    // one pixel transaction with a random gap in front
    task automatic send_pixel(input t_rgb px);
        while ($urandom_range(99) < idle_pct(1'b1)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.take_pixel(px);
        total_sent++;
        stream_pos++;
    endtask

    // steady runs repeat the frame pattern with slight noise, else pure noise
    task automatic send_run(input int n, input bit steady);
        t_rgb px;
        int   p;
        for (int i = 0; i < n; i++) begin
            p = stream_pos % P1_AREA;
            if (steady) begin
                for (int c = 0; c < 3; c++)
                    px[c] = frame_base[p][c] + 8'($urandom_range(0, 3));
            end else begin
                px = 24'($urandom);
            end
            send_pixel(px);
        end
    endtask

    // stop offering and wait for every awaited output
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (tracker.awaited_pixels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        tracker.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic cfg_done();
        i_cfg_we <= 1'b0;
    endtask

    task automatic new_frame_base();
        foreach (frame_base[i]) frame_base[i] = 24'($urandom);
    endtask

    // stimulus
    initial begin
        int chg_pick;
        tracker = new();
        new_frame_base();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: plain pass-through of extreme values
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h0000FF);
        send_pixel(24'h00FF00);
        send_pixel(24'hFF0000);
        send_pixel(24'hA55AC3);
        wait_drained();

        // small frame, all steps on, zero thresholds
        cfg_write(CFG_NEGATE, {20'($urandom), 1'b1});
        cfg_write(CFG_EDGE, {20'($urandom), 1'b1});
        cfg_write(CFG_MOTION, {20'($urandom), 1'b1});
        cfg_write(CFG_WIDTH, 21'(P1_W));
        cfg_write(CFG_HEIGHT, 21'(P1_H));
        cfg_write(CFG_PIX_THR, '0);
        cfg_write(CFG_CHANGE_THR, '0);
        cfg_done();
        stream_pos = 0;
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h000000);
        send_pixel(24'h0000FF);
        send_pixel(24'hFF00FF);
        send_pixel(24'h808080);
        send_pixel(24'h7F7F7F);
        send_pixel(24'hAA55AA);
        send_pixel(24'h55AA55);
        send_pixel(24'h010203);
        send_pixel(24'hFEFDFC);
        send_pixel(24'($urandom));
        send_pixel(24'($urandom));
        send_pixel(24'($urandom));

        // small frames under changing enables and thresholds
        for (int k = 0; k < 14; k++) begin
            wait_drained();
            if (k == 0 || $urandom_range(1))
                cfg_write(CFG_NEGATE, {20'($urandom), 1'($urandom)});
            if (k == 0 || $urandom_range(1))
                cfg_write(CFG_EDGE, {20'($urandom), 1'($urandom)});
            if (k == 0 || $urandom_range(3) != 0)
                cfg_write(CFG_MOTION, {20'($urandom), 1'($urandom_range(0, 3) != 0)});
            case ($urandom_range(3))
                0:       cfg_write(CFG_PIX_THR, '0);
                1:       cfg_write(CFG_PIX_THR, 21'd255);
                default: cfg_write(CFG_PIX_THR, 21'($urandom_range(0, 255)));
            endcase
            chg_pick = $urandom_range(5);
            case (chg_pick)
                0:       cfg_write(CFG_CHANGE_THR, '0);
                1:       cfg_write(CFG_CHANGE_THR, 21'd1048576);
                2:       cfg_write(CFG_CHANGE_THR, 21'(COUNT_MAX));
                default: cfg_write(CFG_CHANGE_THR, 21'($urandom_range(1, 7)));
            endcase
            if ($urandom_range(3) == 0)
                cfg_write(CFG_UNUSED, 21'($urandom));
            cfg_done();
            if (k % 5 == 2)
                new_frame_base();
            // receiver holds off while pixels keep coming
            if (k == 3)
                hold_req <= ~hold_req;
            // sender waits for the pipeline to empty mid-run
            if (k == 6) begin
                send_run(30, 1'b1);
                wait_drained();
            end
            send_run($urandom_range(15, 40), $urandom_range(3) != 0);
        end

        // one pixel wide columns
        wait_drained();
        cfg_write(CFG_WIDTH, '0);
        cfg_write(CFG_HEIGHT, 21'd5);
        cfg_write(CFG_MOTION, {20'($urandom), 1'b1});
        cfg_write(CFG_PIX_THR, 21'd255);
        cfg_write(CFG_CHANGE_THR, 21'd1);
        cfg_done();
        send_run(60, 1'b0);
        wait_drained();
        cfg_write(CFG_PIX_THR, '0);
        cfg_done();
        send_run(40, 1'b0);

        // widest single row frame
        wait_drained();
        cfg_write(CFG_WIDTH, 21'd2047);
        cfg_write(CFG_HEIGHT, '0);
        cfg_write(CFG_EDGE, {20'($urandom), 1'b1});
        cfg_write(CFG_PIX_THR, 21'd100);
        cfg_write(CFG_CHANGE_THR, 21'd100);
        cfg_done();
        send_run(1030, 1'b0);
        // same effective width: frame carries on
        wait_drained();
        cfg_write(CFG_WIDTH, 21'd1024);
        cfg_write(CFG_CHANGE_THR, 21'd1048576);
        cfg_done();
        send_run(20, 1'b0);

        // tallest frame, first pixels only
        wait_drained();
        cfg_write(CFG_HEIGHT, 21'd2047);
        cfg_write(CFG_NEGATE, {20'($urandom), 1'b0});
        cfg_done();
        send_run(40, 1'b0);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (tracker.mismatch_total == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // run limit
    initial begin
        #8000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
